### rtl/vida_pkg.sv
// ----------------------------------------------------------------------------
// vida_pkg
// Shared types and constants of the variable index dynamic average block.
// ----------------------------------------------------------------------------
package vida_pkg;

    localparam int PRICE_W    = 32;
    localparam int MOM_W      = 33;
    localparam int CNT_W      = 17;
    localparam int Q_W        = 17;
    localparam int PROD_W     = 49;
    localparam int WLEN_W     = 7;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [Q_W-1:0]     ONE_Q16    = 17'd65536;
    localparam logic [PROD_W:0]    ROUND_HALF = 50'd32768;
    localparam logic [WLEN_W-1:0]  WLEN_RST   = 7'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd14;
    localparam logic [Q_W-1:0]     ALPHA_RST  = 17'd8738;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd2;

    typedef struct packed {
        logic accept;
        logic sub;
        logic add;
        logic prep;
        logic div_start;
        logic kmul;
        logic mul1;
        logic mul2;
        logic blend;
        logic clear;
    } vida_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic warm;
        logic div_done;
        logic out_free;
    } vida_status_t;

endpackage

### rtl/vida_ram.sv
// ----------------------------------------------------------------------------
// vida_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vida_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/vida_div.sv
// ----------------------------------------------------------------------------
// vida_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num <= den.
// ----------------------------------------------------------------------------
module vida_div #(
    parameter int NUM_W = 38
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [NUM_W:0]                den,
    output logic                          done,
    output logic [vida_pkg::Q_W-1:0]      quot
);

    localparam int CW = $clog2(vida_pkg::Q_W + 1);

    logic [NUM_W:0]             rem_reg;
    logic [NUM_W:0]             rem_next;
    logic [NUM_W:0]             den_reg;
    logic [vida_pkg::Q_W-1:0]   quot_reg;
    logic [vida_pkg::Q_W-1:0]   quot_next;
    logic [CW-1:0]              cnt_reg;
    logic                       first_reg;
    logic [NUM_W+1:0]           trial;
    logic                       fits;

    always_comb
    begin
        trial     = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = fits ? (NUM_W + 1)'(trial - {1'b0, den_reg}) : trial[NUM_W:0];
        quot_next = {quot_reg[vida_pkg::Q_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg   <= CW'(vida_pkg::Q_W);
            first_reg <= 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg   <= cnt_reg - 1'b1;
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = (cnt_reg == CW'(1));
    assign quot = quot_reg;

endmodule

### rtl/vida_dp.sv
// ----------------------------------------------------------------------------
// vida_dp
// Datapath: configuration, momentum ring, running sums, index divide and blend.
// ----------------------------------------------------------------------------
module vida_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vida_pkg::vida_cmd_t               cmd,
    output vida_pkg::vida_status_t            status,
    input  logic                              cfg_write,
    input  logic [vida_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vida_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [vida_pkg::PRICE_W-1:0]      price,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [vida_pkg::PRICE_W-1:0]      average
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int WL_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (WL_W > vida_pkg::WLEN_W) ? WL_W : vida_pkg::WLEN_W;
    localparam int SUM_W = 32 + PTR_W;
    localparam int KP_W  = 2 * vida_pkg::Q_W;

    // configuration
    logic [vida_pkg::WLEN_W-1:0]   wlen_reg;
    logic [vida_pkg::PERIOD_W-1:0] period_reg;
    logic [vida_pkg::Q_W-1:0]      alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= vida_pkg::WLEN_RST;
            period_reg <= vida_pkg::PERIOD_RST;
            alpha_reg  <= vida_pkg::ALPHA_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vida_pkg::REG_WINDOW_LEN: wlen_reg   <= cfg_data[vida_pkg::WLEN_W-1:0];
                vida_pkg::REG_SMOOTHING:  period_reg <= cfg_data[vida_pkg::PERIOD_W-1:0];
                vida_pkg::REG_ALPHA:      alpha_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CMP_W-1:0]           wl_cmp;
    logic [WL_W-1:0]            wl;
    logic [vida_pkg::CNT_W-1:0] need;
    logic [vida_pkg::Q_W-1:0]   alpha_sat;

    always_comb
    begin
        wl_cmp = CMP_W'(wlen_reg);
        if (wl_cmp < CMP_W'(2))
        begin
            wl_cmp = CMP_W'(2);
        end
        if (wl_cmp > CMP_W'(MAX_WINDOW))
        begin
            wl_cmp = CMP_W'(MAX_WINDOW);
        end
        wl        = wl_cmp[WL_W-1:0];
        need      = vida_pkg::CNT_W'(wl) + vida_pkg::CNT_W'(period_reg);
        alpha_sat = alpha_reg[vida_pkg::Q_W-1] ? vida_pkg::ONE_Q16 : alpha_reg;
    end

    // state
    logic [vida_pkg::PRICE_W-1:0] prev_price_reg;
    logic [vida_pkg::PRICE_W-1:0] price_reg;
    logic [vida_pkg::PRICE_W-1:0] prev_avg_reg;
    logic [vida_pkg::PRICE_W-1:0] average_reg;
    logic [vida_pkg::MOM_W-1:0]   mom_reg;
    logic [PTR_W-1:0]             ptr_reg;
    logic [PTR_W-1:0]             cur_ptr_reg;
    logic [PTR_W-1:0]             clr_ptr_reg;
    logic [SUM_W-1:0]             up_sum_reg;
    logic [SUM_W-1:0]             down_sum_reg;
    logic [SUM_W:0]               total_reg;
    logic [SUM_W-1:0]             diff_reg;
    logic [vida_pkg::CNT_W-1:0]   count_reg;
    logic [vida_pkg::Q_W-1:0]     k_reg;
    logic [vida_pkg::PROD_W-1:0]  p1_reg;
    logic [vida_pkg::PROD_W-1:0]  p2_reg;
    logic                         out_valid_reg;

    logic [PTR_W-1:0]             cur_ptr;
    logic [WL_W-1:0]              ptr_inc;
    logic [vida_pkg::MOM_W-1:0]   ring_rdata;
    logic [vida_pkg::MOM_W-1:0]   sum_val;
    logic [vida_pkg::MOM_W-1:0]   sum_mag;
    logic [SUM_W-1:0]             sum_ext;
    logic [vida_pkg::Q_W-1:0]     quot;
    logic [vida_pkg::Q_W-1:0]     index;
    logic [KP_W-1:0]              kprod;
    logic [vida_pkg::PROD_W:0]    acc;
    logic                         warm;

    assign cur_ptr = (WL_W'(ptr_reg) >= wl) ? '0 : ptr_reg;
    assign ptr_inc = WL_W'(cur_ptr_reg) + WL_W'(1);
    assign sum_val = cmd.sub ? ring_rdata : mom_reg;
    assign sum_mag = sum_val[vida_pkg::MOM_W-1] ? (~sum_val + 1'b1) : sum_val;
    assign sum_ext = SUM_W'(sum_mag);
    assign warm    = count_reg < need;
    assign index   = (total_reg == '0) ? '0 : quot;
    assign kprod   = KP_W'(alpha_sat) * KP_W'(index);
    assign acc     = (vida_pkg::PROD_W + 1)'(p1_reg) + (vida_pkg::PROD_W + 1)'(p2_reg)
                     + vida_pkg::ROUND_HALF;

    vida_ram #(
        .WIDTH (vida_pkg::MOM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.clear | cmd.add),
        .waddr (cmd.clear ? clr_ptr_reg : cur_ptr_reg),
        .wdata (cmd.clear ? '0 : mom_reg),
        .re    (cmd.accept),
        .raddr (cur_ptr),
        .rdata (ring_rdata)
    );

    vida_div #(
        .NUM_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (diff_reg),
        .den   (total_reg),
        .done  (status.div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_price_reg <= '0;
            prev_avg_reg   <= '0;
            ptr_reg        <= '0;
            clr_ptr_reg    <= '0;
            up_sum_reg     <= '0;
            down_sum_reg   <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                prev_price_reg <= price;
            end
            if (cmd.sub)
            begin
                if (sum_val[vida_pkg::MOM_W-1])
                begin
                    down_sum_reg <= down_sum_reg - sum_ext;
                end
                else
                begin
                    up_sum_reg <= up_sum_reg - sum_ext;
                end
            end
            if (cmd.add)
            begin
                if (sum_val[vida_pkg::MOM_W-1])
                begin
                    down_sum_reg <= down_sum_reg + sum_ext;
                end
                else
                begin
                    up_sum_reg <= up_sum_reg + sum_ext;
                end
                ptr_reg <= (ptr_inc >= wl) ? '0 : ptr_inc[PTR_W-1:0];
                if (warm)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.blend)
            begin
                prev_avg_reg  <= acc[47:16];
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            price_reg   <= price;
            cur_ptr_reg <= cur_ptr;
            mom_reg     <= (count_reg == '0) ? '0
                           : ({1'b0, price} - {1'b0, prev_price_reg});
        end
        if (cmd.prep)
        begin
            total_reg <= {1'b0, up_sum_reg} + {1'b0, down_sum_reg};
            diff_reg  <= (up_sum_reg >= down_sum_reg) ? (up_sum_reg - down_sum_reg)
                                                      : (down_sum_reg - up_sum_reg);
        end
        if (cmd.kmul)
        begin
            k_reg <= kprod[32:16];
        end
        if (cmd.mul1)
        begin
            p1_reg <= vida_pkg::PROD_W'(price_reg) * vida_pkg::PROD_W'(k_reg);
        end
        if (cmd.mul2)
        begin
            p2_reg <= vida_pkg::PROD_W'(vida_pkg::ONE_Q16 - k_reg)
                      * vida_pkg::PROD_W'(prev_avg_reg);
        end
        if (cmd.blend)
        begin
            average_reg <= acc[47:16];
        end
    end

    assign status.clr_last = (clr_ptr_reg == PTR_W'(MAX_WINDOW - 1));
    assign status.warm     = warm;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign average         = average_reg;

endmodule

### rtl/vida_ctrl.sv
// ----------------------------------------------------------------------------
// vida_ctrl
// Sequencer: ring clear after reset, then one sample at a time.
// ----------------------------------------------------------------------------
module vida_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vida_pkg::vida_status_t status,
    output vida_pkg::vida_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_KMUL,
        ST_MUL1,
        ST_MUL2,
        ST_BLEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = status.warm ? ST_IDLE : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_KMUL;
                end
            end
            ST_KMUL:
            begin
                cmd.kmul   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### rtl/variable_index_dynamic_average_top.sv
// ----------------------------------------------------------------------------
// variable_index_dynamic_average_top
// Adaptive moving average whose smoothing follows a windowed volatility index.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  price   (Q16.16)
//   out      source     out_valid/ out_stall average (Q16.16)
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// A warm-up sample is accepted, subtracted and added; a sample that gives a result
// then also runs prep, the bit-serial index divider, the products and the blend.
// After reset the momentum ring is cleared with in_stall high.
// A finished result waits in the output register; a stalled output holds the
// next result in its final step until the register frees.
// ----------------------------------------------------------------------------
module variable_index_dynamic_average_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [vida_pkg::PRICE_W-1:0]    price,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [vida_pkg::PRICE_W-1:0]    average,
    input  logic                            cfg_write,
    input  logic [vida_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vida_pkg::CFG_DATA_W-1:0] cfg_data
);

    vida_pkg::vida_cmd_t    cmd;
    vida_pkg::vida_status_t status;

    vida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vida_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .price     (price),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .average   (average)
    );

endmodule

### verif/tb_variable_index_dynamic_average_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_index_dynamic_average_top
// Self-checking bench for the adaptive moving average. Price samples go in
// over a valid/stall channel with random gaps. Each accepted transfer is run
// through an in-bench predictor of the volatility-indexed average, and every
// output transfer is checked against the oldest predicted average. Register
// settings change between phases while the block is idle, extremes included.
// Once the output is held off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_variable_index_dynamic_average_top;

    localparam int MAX_WIN     = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 40;
    localparam logic [vida_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    class vida_scoreboard;
        logic [vida_pkg::WLEN_W-1:0]   win_len;
        logic [vida_pkg::PERIOD_W-1:0] smooth_per;
        logic [vida_pkg::Q_W-1:0]      alpha_q;
        logic [vida_pkg::PRICE_W-1:0]  last_price;
        logic [vida_pkg::MOM_W-1:0]    moves [MAX_WIN];
        int unsigned                   slot;
        logic [37:0]                   rise_sum;
        logic [37:0]                   fall_sum;
        logic [vida_pkg::PRICE_W-1:0]  avg_q;
        logic [vida_pkg::CNT_W-1:0]    seen;
        logic [vida_pkg::PRICE_W-1:0]  expected_avg [$];
        int                            errors;

        function new();
            win_len    = vida_pkg::WLEN_RST;
            smooth_per = vida_pkg::PERIOD_RST;
            alpha_q    = vida_pkg::ALPHA_RST;
            last_price = '0;
            foreach (moves[i])
                moves[i] = '0;
            slot     = 0;
            rise_sum = '0;
            fall_sum = '0;
            avg_q    = '0;
            seen     = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [vida_pkg::CFG_IDX_W-1:0] idx,
                              logic [vida_pkg::CFG_DATA_W-1:0] d);
            if (idx == vida_pkg::REG_WINDOW_LEN)
                win_len = d[vida_pkg::WLEN_W-1:0];
            else if (idx == vida_pkg::REG_SMOOTHING)
                smooth_per = d[vida_pkg::PERIOD_W-1:0];
            else if (idx == vida_pkg::REG_ALPHA)
                alpha_q = d[vida_pkg::Q_W-1:0];
        endfunction

        function void adjust(logic [vida_pkg::MOM_W-1:0] m, bit remove);
            logic [vida_pkg::MOM_W-1:0] mag;
            if (m[vida_pkg::MOM_W-1])
            begin
                mag = -m;
                if (remove)
                    fall_sum = fall_sum - 38'(mag);
                else
                    fall_sum = fall_sum + 38'(mag);
            end
            else
            begin
                if (remove)
                    rise_sum = rise_sum - 38'(m);
                else
                    rise_sum = rise_sum + 38'(m);
            end
        endfunction

        // Predicts the average for one accepted price transfer.
        function void note_price(logic [vida_pkg::PRICE_W-1:0] p);
            int unsigned                wl;
            int unsigned                need;
            logic [vida_pkg::MOM_W-1:0] mv;
            logic [63:0]                total;
            logic [63:0]                diff;
            logic [63:0]                idx;
            logic [63:0]                a;
            logic [63:0]                k;
            logic [63:0]                acc;
            wl = win_len;
            if (wl < 2)
                wl = 2;
            if (wl > MAX_WIN)
                wl = MAX_WIN;
            need = wl + smooth_per;
            if (slot >= wl)
                slot = 0;
            mv = (seen == 0) ? '0 : ({1'b0, p} - {1'b0, last_price});
            adjust(moves[slot], 1'b1);
            adjust(mv, 1'b0);
            moves[slot] = mv;
            slot++;
            if (slot >= wl)
                slot = 0;
            last_price = p;
            if (seen < need)
            begin
                seen++;
                return;
            end
            total = 64'(rise_sum) + 64'(fall_sum);
            if (total == 0)
                idx = 0;
            else
            begin
                diff = (rise_sum >= fall_sum) ? 64'(rise_sum - fall_sum)
                                              : 64'(fall_sum - rise_sum);
                idx = (diff << 16) / total;
                if (idx > 64'd65536)
                    idx = 64'd65536;
            end
            a = 64'(alpha_q);
            if (a > 64'd65536)
                a = 64'd65536;
            k = (a * idx) >> 16;
            acc = 64'(p) * k + (64'd65536 - k) * 64'(avg_q) + 64'd32768;
            avg_q = acc[47:16];
            expected_avg.push_back(avg_q);
        endfunction

        function void check_average(logic [vida_pkg::PRICE_W-1:0] got);
            logic [vida_pkg::PRICE_W-1:0] want;
            if (expected_avg.size() == 0)
            begin
                $error("average: nothing expected, actual %h", got);
                errors++;
                return;
            end
            want = expected_avg.pop_front();
            if (got !== want)
            begin
                $error("average: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_avg.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [vida_pkg::PRICE_W-1:0]    price     = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [vida_pkg::PRICE_W-1:0]    average;
    logic                            cfg_write = 1'b0;
    logic [vida_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vida_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    vida_scoreboard               sb;
    bit                           no_idle  = 1'b0;
    bit                           hold_req = 1'b0;
    int                           idle_cycles = 0;
    int unsigned                  items_sent  = 0;
    logic [vida_pkg::PRICE_W-1:0] walk_price  = '0;
    int unsigned                  run_left    = 0;
    int unsigned                  run_mode    = 0;
    int unsigned                  step_shift  = 0;
    int unsigned                  rise_pct    = 50;

    variable_index_dynamic_average_top #(
        .MAX_WINDOW(MAX_WIN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .price     (price),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .average   (average),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly trending walks with random step size, some raw noise and flat runs.
    function automatic logic [vida_pkg::PRICE_W-1:0] next_price();
        int unsigned r;
        logic [vida_pkg::PRICE_W-1:0] step;
        if (run_left == 0)
        begin
            r = $urandom_range(0, 99);
            run_mode   = (r < 70) ? 0 : (r < 85) ? 1 : 2;
            run_left   = $urandom_range(5, 40);
            step_shift = $urandom_range(0, 24);
            rise_pct   = $urandom_range(10, 90);
        end
        run_left--;
        if (run_mode == 0)
        begin
            step = vida_pkg::PRICE_W'($urandom_range(0, 1 << step_shift));
            if ($urandom_range(0, 99) < rise_pct)
                walk_price = walk_price + step;
            else
                walk_price = walk_price - step;
        end
        else if (run_mode == 1)
            walk_price = $urandom;
        return walk_price;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_price(price);
            if (out_valid && !out_stall)
                sb.check_average(average);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = no_idle ? 0 : pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic configure(input int unsigned wl, input int unsigned sp,
                             input int unsigned al);
        cfg_write <= 1'b1;
        cfg_index <= vida_pkg::REG_WINDOW_LEN;
        cfg_data  <= {10'($urandom), 7'(wl)};
        @(posedge clk);
        cfg_index <= vida_pkg::REG_SMOOTHING;
        cfg_data  <= {1'($urandom), 16'(sp)};
        @(posedge clk);
        cfg_index <= vida_pkg::REG_ALPHA;
        cfg_data  <= 17'(al);
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 17'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_price(input logic [vida_pkg::PRICE_W-1:0] p,
                              input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        price    <= p;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned wl, input int unsigned sp,
                             input int unsigned al, input int unsigned count,
                             input bit quiet, input bit pressure);
        configure(wl, sp, al);
        no_idle = quiet;
        if (pressure)
            hold_req = 1'b1;
        for (int i = 0; i < count; i++)
            send_price(next_price(), no_idle ? 0 : pick_gap());
        in_valid <= 1'b0;
        no_idle = 1'b0;
        settle();
    endtask

    initial
    begin
        logic [vida_pkg::PRICE_W-1:0] edge_prices [14];
        logic [vida_pkg::PRICE_W-1:0] flat_prices [6];
        int unsigned r;
        int unsigned al;
        int unsigned sp;
        sb = new();
        edge_prices = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0,
                        32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        flat_prices = '{32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000,
                        32'h0000_FFFF, 32'hFFFF_FFFF};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        // window below range, no extra warm-up, alpha above one
        configure(0, 0, 131071);
        foreach (edge_prices[i])
            send_price(edge_prices[i], pick_gap());
        in_valid <= 1'b0;
        settle();
        // alpha zero: average must hold
        configure(1, 0, 0);
        foreach (flat_prices[i])
            send_price(flat_prices[i], pick_gap());
        in_valid <= 1'b0;
        settle();

        walk_price = $urandom;
        run_phase(vida_pkg::WLEN_RST, vida_pkg::PERIOD_RST, vida_pkg::ALPHA_RST, 150,
                  1'b0, 1'b0);
        run_phase(2, 1, 65536, 200, 1'b0, 1'b0);
        run_phase(64, 0, 32768, 200, 1'b0, 1'b0);
        run_phase(127, 3, 131071, 150, 1'b1, 1'b0);
        run_phase(5, 65535, 12000, 100, 1'b0, 1'b0);
        run_phase(3, 0, 65536, 250, 1'b1, 1'b1);
        while (items_sent < 2000)
        begin
            r  = $urandom_range(0, 99);
            sp = (r < 25) ? 0 : $urandom_range(1, 12);
            r  = $urandom_range(0, 99);
            al = (r < 10) ? 0 : (r < 25) ? 65536 : (r < 35) ? 131071
                                                  : $urandom_range(1, 131071);
            run_phase($urandom_range(0, 127), sp, al, 100,
                      $urandom_range(0, 99) < 20, 1'b0);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
